FILE: src/hilbert_index_transpose_9d_top_macros.svh
// Assertion macros used by the Hilbert transpose port checker.
`ifndef HILBERT_INDEX_TRANSPOSE_9D_TOP_MACROS_SVH
`define HILBERT_INDEX_TRANSPOSE_9D_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HITR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hilbert transpose check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HITR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hilbert transpose check failed");

`endif

FILE: src/hitr_pkg.sv
// Shared constants, types and the plane-step and Gray-encode functions of the Hilbert transpose block.
`default_nettype none

package hitr_pkg;

  localparam int AXIS_BITS = 16;
  localparam int NUM_AXES  = 9;
  localparam int NUM_PLANES = AXIS_BITS - 1;
  localparam int PLANE_W   = $clog2(AXIS_BITS);
  localparam int ORDER_W   = 5;

  typedef logic [AXIS_BITS-1:0]  word_t;
  typedef word_t [NUM_AXES-1:0]  axes_t;
  typedef logic [PLANE_W-1:0]    plane_t;
  typedef logic [ORDER_W-1:0]    order_t;

  // One bit plane of the excess-work undo: walk the axes in order, invert or
  // exchange the bits below the plane against axis 0.
  function automatic axes_t plane_step(axes_t x_in, plane_t p);
    axes_t y;
    word_t low;
    word_t d;
    y   = x_in;
    low = (word_t'(1) << p) - word_t'(1);
    for (int i = 0; i < NUM_AXES; i++) begin
      if (y[i][p]) begin
        y[0] = y[0] ^ low;
      end else begin
        d    = (y[0] ^ y[i]) & low;
        y[0] = y[0] ^ d;
        y[i] = y[i] ^ d;
      end
    end
    return y;
  endfunction

  // Gray encode: prefix XOR across the axes, then fold in the suffix parity
  // of the last axis.
  function automatic axes_t gray_encode(axes_t x_in);
    axes_t y;
    word_t t;
    y = x_in;
    for (int i = 1; i < NUM_AXES; i++) begin
      y[i] = y[i] ^ y[i-1];
    end
    for (int j = 0; j < AXIS_BITS; j++) begin
      t[j] = ^(y[NUM_AXES-1] >> (j + 1));
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      y[i] = y[i] ^ t;
    end
    return y;
  endfunction

endpackage

`default_nettype wire

FILE: src/hitr_channels_if.sv
// Channel interfaces: point request, index result and order register write.
`default_nettype none

interface hitr_axes_if;
  logic valid;
  logic ready;
  logic [15:0] axis_0;
  logic [15:0] axis_1;
  logic [15:0] axis_2;
  logic [15:0] axis_3;
  logic [15:0] axis_4;
  logic [15:0] axis_5;
  logic [15:0] axis_6;
  logic [15:0] axis_7;
  logic [15:0] axis_8;
  modport source (output valid, axis_0, axis_1, axis_2, axis_3, axis_4, axis_5, axis_6,
                  axis_7, axis_8, input ready);
  modport sink (input valid, axis_0, axis_1, axis_2, axis_3, axis_4, axis_5, axis_6,
                axis_7, axis_8, output ready);
  modport mon (input valid, ready, axis_0, axis_1, axis_2, axis_3, axis_4, axis_5, axis_6,
               axis_7, axis_8);
endinterface

interface hitr_words_if;
  logic valid;
  logic ready;
  logic [15:0] word_0;
  logic [15:0] word_1;
  logic [15:0] word_2;
  logic [15:0] word_3;
  logic [15:0] word_4;
  logic [15:0] word_5;
  logic [15:0] word_6;
  logic [15:0] word_7;
  logic [15:0] word_8;
  modport source (output valid, word_0, word_1, word_2, word_3, word_4, word_5, word_6,
                  word_7, word_8, input ready);
  modport sink (input valid, word_0, word_1, word_2, word_3, word_4, word_5, word_6,
                word_7, word_8, output ready);
  modport mon (input valid, ready, word_0, word_1, word_2, word_3, word_4, word_5, word_6,
               word_7, word_8);
endinterface

interface hitr_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] bits_per_axis;
  modport source (output valid, bits_per_axis, input ready);
  modport sink (input valid, bits_per_axis, output ready);
  modport mon (input valid, ready, bits_per_axis);
endinterface

`default_nettype wire

FILE: src/hitr_plane_stage.sv
// One pipeline stage: undo excess work at one bit plane, then register.
`default_nettype none

module hitr_plane_stage (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  hitr_pkg::plane_t     plane_i,
  input  wire                  active_i,
  input  wire                  valid_i,
  output logic                 ready_o,
  input  hitr_pkg::axes_t      data_i,
  output logic                 valid_o,
  input  wire                  ready_i,
  output hitr_pkg::axes_t      data_o
);

  logic            valid_q;
  hitr_pkg::axes_t data_q;
  hitr_pkg::axes_t data_d;

  assign ready_o = !valid_q || ready_i;

  // Planes at or above the order pass through untouched.
  always_comb begin
    if (active_i) begin
      data_d = hitr_pkg::plane_step(data_i, plane_i);
    end else begin
      data_d = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: src/hitr_gray_stage.sv
// Output stage: Gray-encode the words and hold them for the result channel.
`default_nettype none

module hitr_gray_stage (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              valid_i,
  output logic             ready_o,
  input  hitr_pkg::axes_t  data_i,
  output logic             valid_o,
  input  wire              ready_i,
  output hitr_pkg::axes_t  data_o
);

  logic            valid_q;
  hitr_pkg::axes_t data_q;
  hitr_pkg::axes_t data_d;

  assign ready_o = !valid_q || ready_i;
  assign data_d  = hitr_pkg::gray_encode(data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: src/hilbert_index_transpose_9d_top.sv
// Top level of the nine-axis Hilbert index generator in transposed form.
`default_nettype none

// Takes one nine-coordinate point per request on axes_i and returns its
// Hilbert index as nine transposed words on words_o: bit b of word_0..word_8
// is the nine-bit index group of plane b, word_0 holding its top bit. The
// curve order comes from the bits_per_axis register written on cfg_i (reset
// 16); 0 acts as 1 and values above 16 act as 16. Coordinate bits at or above
// the order are ignored and the matching result bits read zero. Write the
// register only while no request is in flight. Throughput is one point per
// clock while the result side does not stall. A request passes fifteen register
// stages, one per bit plane from 15 down to 1, each walking the nine axes of
// that plane, then one Gray-encode stage that is also the output register.
// Every stage holds its own valid bit and takes new data whenever it is empty
// or its successor moves, so bubbles close up and a stalled result does not
// block requests until the whole pipeline is full. cfg_i is always ready.
module hilbert_index_transpose_9d_top (
  input  wire                clk_i,
  input  wire                rst_ni,
  hitr_axes_if.sink          axes_i,
  hitr_words_if.source       words_o,
  hitr_cfg_if.sink           cfg_i
);

  localparam int NP = hitr_pkg::NUM_PLANES;

  hitr_pkg::order_t cfg_q;
  hitr_pkg::order_t order_eff;
  logic [hitr_pkg::AXIS_BITS:0] mask_wide;
  hitr_pkg::word_t  mask;

  logic            valid_s [0:NP];
  logic            ready_s [0:NP];
  hitr_pkg::axes_t data_s  [0:NP];
  hitr_pkg::axes_t data_out;

  // Order register: always ready, hold the full five-bit write.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= hitr_pkg::order_t'(hitr_pkg::AXIS_BITS);
    end else if (cfg_i.valid) begin
      cfg_q <= cfg_i.bits_per_axis;
    end
  end

  // Clamp the order to 1..AXIS_BITS and build the coordinate mask.
  always_comb begin
    if (cfg_q == '0) begin
      order_eff = hitr_pkg::order_t'(1);
    end else if (int'(cfg_q) > hitr_pkg::AXIS_BITS) begin
      order_eff = hitr_pkg::order_t'(hitr_pkg::AXIS_BITS);
    end else begin
      order_eff = cfg_q;
    end
  end

  assign mask_wide = ((hitr_pkg::AXIS_BITS + 1)'(1) << order_eff)
                     - (hitr_pkg::AXIS_BITS + 1)'(1);
  assign mask      = mask_wide[hitr_pkg::AXIS_BITS-1:0];

  // Request side: drop unused coordinate bits on the way in.
  assign valid_s[0]   = axes_i.valid;
  assign axes_i.ready = ready_s[0];
  assign data_s[0][0] = axes_i.axis_0 & mask;
  assign data_s[0][1] = axes_i.axis_1 & mask;
  assign data_s[0][2] = axes_i.axis_2 & mask;
  assign data_s[0][3] = axes_i.axis_3 & mask;
  assign data_s[0][4] = axes_i.axis_4 & mask;
  assign data_s[0][5] = axes_i.axis_5 & mask;
  assign data_s[0][6] = axes_i.axis_6 & mask;
  assign data_s[0][7] = axes_i.axis_7 & mask;
  assign data_s[0][8] = axes_i.axis_8 & mask;

  // One stage per bit plane, top plane first; planes at or above the order idle.
  for (genvar k = 0; k < NP; k++) begin : g_plane
    localparam int PLANE = hitr_pkg::AXIS_BITS - 1 - k;
    logic act;
    assign act = PLANE < int'(order_eff);

    hitr_plane_stage u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .plane_i  (hitr_pkg::plane_t'(PLANE)),
      .active_i (act),
      .valid_i  (valid_s[k]),
      .ready_o  (ready_s[k]),
      .data_i   (data_s[k]),
      .valid_o  (valid_s[k+1]),
      .ready_i  (ready_s[k+1]),
      .data_o   (data_s[k+1])
    );
  end

  // Gray encode into the output register.
  hitr_gray_stage u_gray (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[NP]),
    .ready_o (ready_s[NP]),
    .data_i  (data_s[NP]),
    .valid_o (words_o.valid),
    .ready_i (words_o.ready),
    .data_o  (data_out)
  );

  assign words_o.word_0 = data_out[0];
  assign words_o.word_1 = data_out[1];
  assign words_o.word_2 = data_out[2];
  assign words_o.word_3 = data_out[3];
  assign words_o.word_4 = data_out[4];
  assign words_o.word_5 = data_out[5];
  assign words_o.word_6 = data_out[6];
  assign words_o.word_7 = data_out[7];
  assign words_o.word_8 = data_out[8];

endmodule

`default_nettype wire

FILE: src/hitr_port_checker.sv
// Port-level checker for the Hilbert transpose top, bound to every instance.
`default_nettype none

`include "hilbert_index_transpose_9d_top_macros.svh"

module hitr_port_checker (
  input wire            clk_i,
  input wire            rst_ni,
  hitr_axes_if.sink     axes,
  hitr_words_if.source  words,
  hitr_cfg_if.sink      cfg
);

  logic [4:0]  order_q;
  logic [4:0]  order_eff;
  logic [16:0] mask_wide;
  logic [15:0] hi_mask;
  logic        words_clean;

  // Track the order register from the write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 5'd16;
    end else if (cfg.valid && cfg.ready) begin
      order_q <= cfg.bits_per_axis;
    end
  end

  always_comb begin
    if (order_q == 5'd0) begin
      order_eff = 5'd1;
    end else if (order_q > 5'd16) begin
      order_eff = 5'd16;
    end else begin
      order_eff = order_q;
    end
  end

  assign mask_wide = (17'd1 << order_eff) - 17'd1;
  assign hi_mask   = ~mask_wide[15:0];

  assign words_clean = ((words.word_0 | words.word_1 | words.word_2 | words.word_3 |
                         words.word_4 | words.word_5 | words.word_6 | words.word_7 |
                         words.word_8) & hi_mask) == 16'd0;

  `HITR_ASSERT_NOW(a_high_bits_zero, words.valid, words_clean)
  `HITR_ASSERT_NOW(a_empty_out_takes, !words.valid, axes.ready)
  `HITR_ASSERT_NEXT(a_out_valid_holds, words.valid && !words.ready, words.valid)
  `HITR_ASSERT_NEXT(a_out_data_holds, words.valid && !words.ready,
                    $stable(words.word_0) && $stable(words.word_4) && $stable(words.word_8))

endmodule

bind hilbert_index_transpose_9d_top hitr_port_checker u_hitr_port_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .axes   (axes_i),
  .words  (words_o),
  .cfg    (cfg_i)
);

`default_nettype wire

FILE: sim/hilbert_index_transpose_9d_top_test.sv
// Self-checking testbench for the nine-axis Hilbert transpose index generator.
`timescale 1ns / 1ps

module hilbert_index_transpose_9d_top_test;

  // Stop the run here even if the block hangs; the slowest legal run is far shorter.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Hold the result side off this long once, so the pipeline fills and stalls requests.
  localparam int unsigned LONG_HOLD   = 150;
  // Start the long hold-off once this many results have come.
  localparam int unsigned HOLD_AFTER  = 200;
  // Cap on printed mismatch lines; later ones are still counted.
  localparam int unsigned PRINT_CAP   = 100;
  // Cycles to keep watching after the last result: the block's latency with margin.
  localparam int unsigned TAIL_CYCLES = 40;

  logic clk_i;
  logic rst_ni;

  hitr_axes_if  axes_if ();
  hitr_words_if words_if ();
  hitr_cfg_if   cfg_if ();

  hilbert_index_transpose_9d_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .axes_i  (axes_if),
    .words_o (words_if),
    .cfg_i   (cfg_if)
  );

  // Points waiting to be sent, and the transposed indexes owed by the block, oldest first.
  hitr_pkg::axes_t point_q[$];
  hitr_pkg::axes_t index_q[$];

  // Curve order as the block should hold it; follows every accepted register write.
  hitr_pkg::order_t curve_order = hitr_pkg::order_t'(16);

  int unsigned cycle_cnt    = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned printed_cnt  = 0;
  int unsigned send_gap     = 0;
  int unsigned hold_left    = 0;
  bit          long_hold_done = 1'b0;
  // Phases with these set run without idle cycles on that side.
  bit          src_steady   = 1'b0;
  bit          sink_steady  = 1'b0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Expected transposed Hilbert index of one point at the given register value.
  function automatic hitr_pkg::axes_t hilbert_words(hitr_pkg::axes_t pt,
                                                    hitr_pkg::order_t order_reg);
    int unsigned     ord;
    logic [31:0]     coord [hitr_pkg::NUM_AXES];
    logic [31:0]     top_bit;
    logic [31:0]     keep;
    logic [31:0]     below;
    logic [31:0]     diff;
    logic [31:0]     fold;
    hitr_pkg::axes_t res;
    // Clamp the order into 1..AXIS_BITS.
    ord = order_reg;
    if (ord < 1) ord = 1;
    if (ord > hitr_pkg::AXIS_BITS) ord = hitr_pkg::AXIS_BITS;
    top_bit = 32'd1 << (ord - 1);
    keep    = ((top_bit - 32'd1) << 1) | 32'd1;
    for (int i = 0; i < hitr_pkg::NUM_AXES; i++) begin
      coord[i] = {16'd0, pt[i]} & keep;
    end
    // Undo excess work, top plane down to plane 1.
    for (logic [31:0] q = top_bit; q > 32'd1; q = q >> 1) begin
      below = q - 32'd1;
      for (int i = 0; i < hitr_pkg::NUM_AXES; i++) begin
        if ((coord[i] & q) != 0) begin
          coord[0] = coord[0] ^ below;
        end else begin
          diff     = (coord[0] ^ coord[i]) & below;
          coord[0] = coord[0] ^ diff;
          coord[i] = coord[i] ^ diff;
        end
      end
    end
    // Gray encode: prefix XOR chain, then fold the last axis back into all words.
    for (int i = 1; i < hitr_pkg::NUM_AXES; i++) begin
      coord[i] = coord[i] ^ coord[i-1];
    end
    fold = 32'd0;
    for (logic [31:0] q = top_bit; q > 32'd1; q = q >> 1) begin
      if ((coord[hitr_pkg::NUM_AXES-1] & q) != 0) fold = fold ^ (q - 32'd1);
    end
    for (int i = 0; i < hitr_pkg::NUM_AXES; i++) begin
      res[i] = hitr_pkg::word_t'((coord[i] ^ fold) & keep);
    end
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Coordinate biased toward the edges: zero, all ones, a single bit, else uniform.
  function automatic hitr_pkg::word_t rand_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return hitr_pkg::word_t'(0);
      1: return '1;
      2: return hitr_pkg::word_t'(1) << $urandom_range(0, hitr_pkg::AXIS_BITS - 1);
      default: return hitr_pkg::word_t'($urandom);
    endcase
  endfunction

  // Driver: advance to the next pending point once the current request is taken.
  always @(posedge clk_i) begin
    hitr_pkg::axes_t pt;
    if (!rst_ni) begin
      axes_if.valid <= 1'b0;
    end else if (!axes_if.valid || axes_if.ready) begin
      if (send_gap > 0) begin
        axes_if.valid <= 1'b0;
        send_gap--;
      end else if (point_q.size() > 0) begin
        pt = point_q.pop_front();
        axes_if.valid  <= 1'b1;
        axes_if.axis_0 <= pt[0];
        axes_if.axis_1 <= pt[1];
        axes_if.axis_2 <= pt[2];
        axes_if.axis_3 <= pt[3];
        axes_if.axis_4 <= pt[4];
        axes_if.axis_5 <= pt[5];
        axes_if.axis_6 <= pt[6];
        axes_if.axis_7 <= pt[7];
        axes_if.axis_8 <= pt[8];
        send_gap = src_steady ? 0 : idle_len();
      end else begin
        axes_if.valid <= 1'b0;
      end
    end
  end

  // Result side ready: random stalls, plus one long hold-off counted here.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      words_if.ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD - 1;
      words_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      words_if.ready <= 1'b0;
    end else if (sink_steady || $urandom_range(0, 3) != 0) begin
      words_if.ready <= 1'b1;
    end else begin
      words_if.ready <= 1'b0;
      hold_left = idle_len();
    end
  end

  // Monitor: predict on every accepted request, check every accepted result.
  always @(posedge clk_i) begin
    hitr_pkg::axes_t got;
    hitr_pkg::axes_t want;
    if (rst_ni) begin
      if (axes_if.valid && axes_if.ready) begin
        // Packed order: the last element of the concatenation lands on axis 0.
        got = {axes_if.axis_8, axes_if.axis_7, axes_if.axis_6, axes_if.axis_5, axes_if.axis_4,
               axes_if.axis_3, axes_if.axis_2, axes_if.axis_1, axes_if.axis_0};
        index_q.push_back(hilbert_words(got, curve_order));
      end
      if (cfg_if.valid && cfg_if.ready) begin
        curve_order = cfg_if.bits_per_axis;
      end
      if (words_if.valid && words_if.ready) begin
        results_seen++;
        got = {words_if.word_8, words_if.word_7, words_if.word_6, words_if.word_5,
               words_if.word_4, words_if.word_3, words_if.word_2, words_if.word_1,
               words_if.word_0};
        if (index_q.size() == 0) begin
          mismatch_cnt++;
          if (printed_cnt < PRINT_CAP) begin
            printed_cnt++;
            $display("%0t: result with nothing expected, got %h", $time, got);
          end
        end else begin
          want = index_q.pop_front();
          for (int i = 0; i < hitr_pkg::NUM_AXES; i++) begin
            if (got[i] !== want[i]) begin
              mismatch_cnt++;
              if (printed_cnt < PRINT_CAP) begin
                printed_cnt++;
                $display("%0t: word_%0d expected %h got %h (order %0d)", $time, i, want[i],
                         got[i], curve_order);
              end
            end
          end
        end
      end
    end
  end

  // Watchdog: a hang ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Queue the same value on all nine axes.
  task automatic add_uniform(input hitr_pkg::word_t v);
    hitr_pkg::axes_t pt;
    for (int i = 0; i < hitr_pkg::NUM_AXES; i++) pt[i] = v;
    point_q.push_back(pt);
  endtask

  task automatic add_random(input int unsigned n);
    hitr_pkg::axes_t pt;
    repeat (n) begin
      for (int i = 0; i < hitr_pkg::NUM_AXES; i++) pt[i] = rand_coord();
      point_q.push_back(pt);
    end
  endtask

  // Hold the initial block until every queued point is taken and every result is back.
  task automatic drain();
    while (point_q.size() != 0 || axes_if.valid || index_q.size() != 0) @(posedge clk_i);
  endtask

  // Write the curve order; only called with the block idle.
  task automatic write_order(input hitr_pkg::order_t v);
    @(posedge clk_i);
    cfg_if.valid         <= 1'b1;
    cfg_if.bits_per_axis <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    hitr_pkg::axes_t pt;
    // Known values on every block input from time zero.
    rst_ni               = 1'b0;
    axes_if.valid        = 1'b0;
    axes_if.axis_0       = '0;
    axes_if.axis_1       = '0;
    axes_if.axis_2       = '0;
    axes_if.axis_3       = '0;
    axes_if.axis_4       = '0;
    axes_if.axis_5       = '0;
    axes_if.axis_6       = '0;
    axes_if.axis_7       = '0;
    axes_if.axis_8       = '0;
    words_if.ready       = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.bits_per_axis = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed points at the reset order of 16: extremes and top-plane patterns.
    add_uniform(hitr_pkg::word_t'(16'h0000));
    add_uniform(hitr_pkg::word_t'(16'hFFFF));
    add_uniform(hitr_pkg::word_t'(16'h8000));
    add_uniform(hitr_pkg::word_t'(16'h7FFF));
    add_uniform(hitr_pkg::word_t'(16'h0001));
    for (int i = 0; i < hitr_pkg::NUM_AXES; i++) begin
      pt[i] = i[0] ? hitr_pkg::word_t'(16'hAAAA) : hitr_pkg::word_t'(16'h5555);
    end
    point_q.push_back(pt);
    for (int k = 0; k < hitr_pkg::NUM_AXES; k += 4) begin
      // Top bit on a single axis: first, middle and last axis.
      pt = '0;
      pt[k] = hitr_pkg::word_t'(16'h8000);
      point_q.push_back(pt);
    end
    for (int i = 0; i < hitr_pkg::NUM_AXES; i++) pt[i] = hitr_pkg::word_t'(i);
    point_q.push_back(pt);
    drain();

    // Order zero acts as order one; every bit above bit 0 must be dropped.
    write_order(hitr_pkg::order_t'(0));
    add_uniform(hitr_pkg::word_t'(16'hFFFF));
    add_uniform(hitr_pkg::word_t'(16'h0001));
    add_random(40);
    drain();

    // Order one: only the XOR chain on bit 0.
    write_order(hitr_pkg::order_t'(1));
    add_random(40);
    drain();

    // Orders above the axis width clamp to 16.
    write_order(hitr_pkg::order_t'(31));
    add_uniform(hitr_pkg::word_t'(16'hFFFF));
    add_random(40);
    drain();
    write_order(hitr_pkg::order_t'(17));
    add_random(30);
    drain();

    // Full order with the sender never idle; the long hold-off lands in this phase
    // and should back the pipeline up into the request side.
    write_order(hitr_pkg::order_t'(16));
    src_steady = 1'b1;
    add_random(250);
    drain();
    src_steady = 1'b0;

    // Random orders in between, one phase with both sides steady.
    for (int p = 0; p < 6; p++) begin
      write_order(hitr_pkg::order_t'($urandom_range(2, 15)));
      src_steady  = (p == 2);
      sink_steady = (p == 2);
      add_random(60);
      drain();
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;

    write_order(hitr_pkg::order_t'(16));
    add_random(90);
    drain();

    // Catch any stray result the block might still produce.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && index_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
